/* rtl/dwcp_pkg.sv */
// dwcp_pkg: shared widths, field layout, reset values, command and status types
// for the delay wire chamber position core. No dependencies.
package dwcp_pkg;

    localparam int TIME_BITS = 22;

    // internal arithmetic widths
    localparam int SUM_W   = TIME_BITS + 1;
    localparam int DIFF_W  = TIME_BITS + 1;
    localparam int RAW_W   = TIME_BITS + 6;
    localparam int POS_W   = TIME_BITS + 7;
    localparam int COEF_W  = 13;
    localparam int PROD_W  = POS_W + COEF_W;

    // mean divider: eight quotient bits per cycle
    localparam int DIV_STEPS = 8;
    localparam int DIV_W     = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_CYC   = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

    // field widths
    localparam int CH_W      = 2;
    localparam int CAL_N     = 4;
    localparam int CAL_W     = 64;
    localparam int WIN_W     = 14;
    localparam int THR_W     = 3;
    localparam int VCNT_W    = 3;
    localparam int GCNT_W    = 3;
    localparam int POS_OUT_W = 16;
    localparam int MEAN_W    = 21;
    localparam int MQ_W      = (DIV_W > MEAN_W) ? DIV_W : MEAN_W;

    // calibration word layout
    localparam int SLOPE_W    = 12;
    localparam int OFF_W      = 14;
    localparam int ROT_W      = 12;
    localparam int SLOPEX_LSB = 52;
    localparam int SLOPEY_LSB = 40;
    localparam int OFFX_LSB   = 26;
    localparam int OFFY_LSB   = 12;
    localparam int ROT_LSB    = 0;

    // stream widths
    localparam int S_TDATA_W  = ((4 * TIME_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * POS_OUT_W + 3 + MEAN_W + VCNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd5;

    localparam logic [CAL_W-1:0] CAL_RESET    = 64'd1477541317591433216;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 14'd12800;
    localparam logic [THR_W-1:0] THRESH_RESET = 3'd3;

    localparam logic [GCNT_W-1:0] GCNT_MAX = 3'd7;
    localparam logic [MEAN_W-1:0] MEAN_MAX = 21'h1FFFFF;
    localparam logic signed [POS_W-1:0] POS_HI = POS_W'(32767);
    localparam logic signed [POS_W-1:0] POS_LO = POS_W'(-32768);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MX,
        OP_MY,
        OP_MRY,
        OP_MRX
    } mul_op_t;

    typedef struct packed {
        logic    load;
        mul_op_t op;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [POS_OUT_W-1:0] sat_pos(input logic signed [POS_W-1:0] v);
        logic [POS_OUT_W-1:0] r;
        if (v > POS_HI) begin
            r = POS_HI[POS_OUT_W-1:0];
        end else if (v < POS_LO) begin
            r = POS_LO[POS_OUT_W-1:0];
        end else begin
            r = v[POS_OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/delay_wire_chamber_position_core.sv */
// delay_wire_chamber_position_core: top level of the chamber position core.
// Joins dwcp_ctrl and dwcp_datapath; uses dwcp_pkg.
//
// One chamber (four TDC times) is taken per input beat and gives one result beat.
// A chamber goes through an accept state, four passes through the single shared
// multiplier (raw X, raw Y, X rotation, Y rotation) and a final state that writes
// the result register; the mean divider works 8 quotient bits per cycle
// alongside the multiplier passes. s_tready is high only between chambers, but
// a new chamber is taken while the previous result still waits in the output
// register. Configuration writes are always accepted and must only be issued
// while no chamber is in flight.
module delay_wire_chamber_position_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input beat
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dwcp_pkg::S_TDATA_W-1:0]      s_tdata,   // t_left, t_right, t_down, t_up
    input  logic [dwcp_pkg::CH_W-1:0]           s_tuser,   // chamber
    input  logic                                s_tlast,   // last_chamber
    // result beat
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // x_position, y_position, good_x, good_y, good_point, mean_time, valid_count,
    // track_ok, zero pad
    output logic [dwcp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [dwcp_pkg::CH_W-1:0]           m_tuser,   // chamber_out
    output logic                                m_tlast,   // last_out
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwcp_pkg::CAL_W-1:0]          cfg_data
);

    dwcp_pkg::dp_cmd_t    cmd;
    dwcp_pkg::dp_status_t status;

    dwcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dwcp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/dwcp_div.sv */
// dwcp_div: radix-2 restoring divider of the time sum by the hit count,
// eight quotient bits per cycle. Uses dwcp_pkg.
module dwcp_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [dwcp_pkg::SUM_W-1:0]        dividend,
    input  logic [dwcp_pkg::VCNT_W-1:0]       divisor,
    output logic [dwcp_pkg::DIV_W-1:0]        quotient,
    output logic                              done
);

    logic [dwcp_pkg::DIV_W-1:0]     num_reg, num_next;
    logic [1:0]                     rem_reg, rem_next;
    logic [dwcp_pkg::DIV_CNT_W-1:0] cnt_reg;

    always_comb begin
        logic [dwcp_pkg::DIV_W-1:0] num;
        logic [2:0]                 r;
        num = num_reg;
        r   = {1'b0, rem_reg};
        for (int i = 0; i < dwcp_pkg::DIV_STEPS; i++) begin
            r   = {r[1:0], num[dwcp_pkg::DIV_W-1]};
            num = {num[dwcp_pkg::DIV_W-2:0], 1'b0};
            if (r >= divisor) begin
                r      = r - divisor;
                num[0] = 1'b1;
            end
        end
        num_next = num;
        rem_next = r[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= dwcp_pkg::DIV_CNT_W'(dwcp_pkg::DIV_CYC);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dwcp_pkg::DIV_W'(dividend);
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = num_reg;
    assign done     = (cnt_reg == '0);

endmodule

/* rtl/dwcp_datapath.sv */
// dwcp_datapath: configuration registers, input capture, shared multiplier for
// raw and aligned coordinates, mean divider, event counter and output register.
// Uses dwcp_pkg and dwcp_div.
module dwcp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dwcp_pkg::dp_cmd_t                   cmd,
    output dwcp_pkg::dp_status_t                status,
    input  logic [dwcp_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [dwcp_pkg::CH_W-1:0]           s_tuser,
    input  logic                                s_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwcp_pkg::CAL_W-1:0]          cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dwcp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [dwcp_pkg::CH_W-1:0]           m_tuser,
    output logic                                m_tlast
);

    localparam int TB = dwcp_pkg::TIME_BITS;

    // configuration
    logic [dwcp_pkg::CAL_W-1:0] cal_reg [dwcp_pkg::CAL_N];
    logic [dwcp_pkg::WIN_W-1:0] window_reg;
    logic [dwcp_pkg::THR_W-1:0] thresh_reg;

    // input decode
    logic signed [TB-1:0]             t_left, t_right, t_down, t_up;
    logic [3:0]                       t_valid;
    logic [dwcp_pkg::SUM_W-1:0]       sum_in;
    logic [dwcp_pkg::VCNT_W-1:0]      vcnt_in;
    logic signed [dwcp_pkg::DIFF_W-1:0] dx_in, dy_in;

    // per item
    logic [dwcp_pkg::CH_W-1:0]          ch_reg;
    logic                               last_reg;
    logic signed [dwcp_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic                               vx_reg, vy_reg;
    logic [dwcp_pkg::VCNT_W-1:0]        vcnt_reg;
    logic signed [dwcp_pkg::RAW_W-1:0]  rawx_reg, rawy_reg;
    logic signed [dwcp_pkg::POS_W-1:0]  ax_reg, ay_reg;
    logic                               gx_reg, gy_reg;

    // calibration fields of the current chamber
    logic [dwcp_pkg::CAL_W-1:0]         cal_sel;
    logic [dwcp_pkg::SLOPE_W-1:0]       slopex, slopey;
    logic signed [dwcp_pkg::OFF_W-1:0]  offx, offy;
    logic signed [dwcp_pkg::ROT_W-1:0]  rot;

    // shared multiplier
    logic signed [dwcp_pkg::POS_W-1:0]  mul_a, rx;
    logic signed [dwcp_pkg::COEF_W-1:0] mul_b;
    logic signed [dwcp_pkg::PROD_W-1:0] prod;
    logic signed [dwcp_pkg::RAW_W-1:0]  raw_new;
    logic signed [dwcp_pkg::POS_W-1:0]  rot_term, ax_new, ay_new;
    logic signed [dwcp_pkg::RAW_W-1:0]  win_s;
    logic                               gx_new, gy_new;

    // mean
    logic [dwcp_pkg::DIV_W-1:0]   quot;
    logic                         div_done;
    logic [dwcp_pkg::MQ_W-1:0]    quot_ext;
    logic [dwcp_pkg::MEAN_W-1:0]  mean_val;

    // event counter and output stage
    logic [dwcp_pkg::GCNT_W-1:0]  gcnt_reg, gcnt_next, gcnt_inc;
    logic                         good_pt, track;
    logic                         m_valid_reg, m_valid_next;
    logic [dwcp_pkg::CH_W-1:0]    o_ch_reg;
    logic [dwcp_pkg::POS_OUT_W-1:0] o_x_reg, o_y_reg;
    logic                         o_gx_reg, o_gy_reg, o_gp_reg;
    logic [dwcp_pkg::MEAN_W-1:0]  o_mean_reg;
    logic [dwcp_pkg::VCNT_W-1:0]  o_vcnt_reg;
    logic                         o_track_reg, o_last_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dwcp_pkg::CAL_N; i++) begin
                cal_reg[i] <= dwcp_pkg::CAL_RESET;
            end
            window_reg <= dwcp_pkg::WINDOW_RESET;
            thresh_reg <= dwcp_pkg::THRESH_RESET;
        end else if (cfg_valid) begin
            if (cfg_index <= dwcp_pkg::REG_CAL3) begin
                cal_reg[cfg_index[1:0]] <= cfg_data;
            end else if (cfg_index == dwcp_pkg::REG_WINDOW) begin
                window_reg <= cfg_data[dwcp_pkg::WIN_W-1:0];
            end else if (cfg_index == dwcp_pkg::REG_THRESH) begin
                thresh_reg <= cfg_data[dwcp_pkg::THR_W-1:0];
            end
        end
    end

    // input decode
    assign t_left  = s_tdata[0*TB +: TB];
    assign t_right = s_tdata[1*TB +: TB];
    assign t_down  = s_tdata[2*TB +: TB];
    assign t_up    = s_tdata[3*TB +: TB];
    assign t_valid = {!t_up[TB-1], !t_down[TB-1], !t_right[TB-1], !t_left[TB-1]};

    assign sum_in = (t_valid[0] ? dwcp_pkg::SUM_W'(t_left[TB-2:0])  : '0)
                  + (t_valid[1] ? dwcp_pkg::SUM_W'(t_right[TB-2:0]) : '0)
                  + (t_valid[2] ? dwcp_pkg::SUM_W'(t_down[TB-2:0])  : '0)
                  + (t_valid[3] ? dwcp_pkg::SUM_W'(t_up[TB-2:0])    : '0);
    assign vcnt_in = {2'b00, t_valid[0]} + {2'b00, t_valid[1]}
                   + {2'b00, t_valid[2]} + {2'b00, t_valid[3]};
    assign dx_in = dwcp_pkg::DIFF_W'(t_left) - dwcp_pkg::DIFF_W'(t_right);
    assign dy_in = dwcp_pkg::DIFF_W'(t_down) - dwcp_pkg::DIFF_W'(t_up);

    // calibration fields
    assign cal_sel = cal_reg[ch_reg];
    assign slopex  = cal_sel[dwcp_pkg::SLOPEX_LSB +: dwcp_pkg::SLOPE_W];
    assign slopey  = cal_sel[dwcp_pkg::SLOPEY_LSB +: dwcp_pkg::SLOPE_W];
    assign offx    = $signed(cal_sel[dwcp_pkg::OFFX_LSB +: dwcp_pkg::OFF_W]);
    assign offy    = $signed(cal_sel[dwcp_pkg::OFFY_LSB +: dwcp_pkg::OFF_W]);
    assign rot     = $signed(cal_sel[dwcp_pkg::ROT_LSB +: dwcp_pkg::ROT_W]);

    // rotation operand for y: aligned x when good, raw x otherwise (zero when no x hit)
    assign rx = gx_reg ? ax_reg : dwcp_pkg::POS_W'(rawx_reg);

    always_comb begin
        case (cmd.op)
            dwcp_pkg::OP_MX: begin
                mul_a = dwcp_pkg::POS_W'(dx_reg);
                mul_b = $signed({1'b0, slopex});
            end
            dwcp_pkg::OP_MY: begin
                mul_a = dwcp_pkg::POS_W'(dy_reg);
                mul_b = $signed({1'b0, slopey});
            end
            dwcp_pkg::OP_MRY: begin
                mul_a = dwcp_pkg::POS_W'(rawy_reg);
                mul_b = dwcp_pkg::COEF_W'(rot);
            end
            dwcp_pkg::OP_MRX: begin
                mul_a = rx;
                mul_b = dwcp_pkg::COEF_W'(rot);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = dwcp_pkg::PROD_W'(mul_a) * dwcp_pkg::PROD_W'(mul_b);
    assign raw_new  = $signed(prod[dwcp_pkg::RAW_W+7:8]);
    assign rot_term = dwcp_pkg::POS_W'($signed(prod[dwcp_pkg::PROD_W-1:14]));
    assign ax_new   = dwcp_pkg::POS_W'(rawx_reg) - dwcp_pkg::POS_W'(offx) - rot_term;
    assign ay_new   = dwcp_pkg::POS_W'(rawy_reg) - dwcp_pkg::POS_W'(offy) + rot_term;

    assign win_s  = $signed(dwcp_pkg::RAW_W'(window_reg));
    assign gx_new = vx_reg && (rawx_reg <= win_s) && (rawx_reg >= -win_s);
    assign gy_new = vy_reg && (rawy_reg <= win_s) && (rawy_reg >= -win_s);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg   <= s_tuser;
            last_reg <= s_tlast;
            dx_reg   <= dx_in;
            dy_reg   <= dy_in;
            vx_reg   <= t_valid[0] & t_valid[1];
            vy_reg   <= t_valid[2] & t_valid[3];
            vcnt_reg <= vcnt_in;
        end
        case (cmd.op)
            dwcp_pkg::OP_MX: begin
                rawx_reg <= vx_reg ? raw_new : '0;
            end
            dwcp_pkg::OP_MY: begin
                rawy_reg <= vy_reg ? raw_new : '0;
            end
            dwcp_pkg::OP_MRY: begin
                ax_reg <= ax_new;
                gx_reg <= gx_new;
                gy_reg <= gy_new;
            end
            dwcp_pkg::OP_MRX: begin
                ay_reg <= ay_new;
            end
            default: begin
            end
        endcase
    end

    // mean of the valid times
    dwcp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load),
        .dividend (sum_in),
        .divisor  (vcnt_reg),
        .quotient (quot),
        .done     (div_done)
    );

    assign quot_ext = dwcp_pkg::MQ_W'(quot);

    always_comb begin
        if (vcnt_reg == '0) begin
            mean_val = '0;
        end else if (quot_ext > dwcp_pkg::MQ_W'(dwcp_pkg::MEAN_MAX)) begin
            mean_val = dwcp_pkg::MEAN_MAX;
        end else begin
            mean_val = quot_ext[dwcp_pkg::MEAN_W-1:0];
        end
    end

    // good chamber count per event
    assign good_pt  = gx_reg & gy_reg;
    assign gcnt_inc = (good_pt && gcnt_reg != dwcp_pkg::GCNT_MAX) ? gcnt_reg + 1'b1 : gcnt_reg;
    assign track    = last_reg && (gcnt_inc >= thresh_reg);

    always_comb begin
        if (cmd.out_load) begin
            gcnt_next = last_reg ? '0 : gcnt_inc;
        end else begin
            gcnt_next = gcnt_reg;
        end
    end

    // output register
    assign status.out_free = !m_valid_reg || m_tready;
    assign status.div_done = div_done;
    assign m_valid_next    = cmd.out_load || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            gcnt_reg    <= gcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_ch_reg    <= ch_reg;
            o_x_reg     <= gx_reg ? dwcp_pkg::sat_pos(ax_reg) : '0;
            o_y_reg     <= gy_reg ? dwcp_pkg::sat_pos(ay_reg) : '0;
            o_gx_reg    <= gx_reg;
            o_gy_reg    <= gy_reg;
            o_gp_reg    <= good_pt;
            o_mean_reg  <= mean_val;
            o_vcnt_reg  <= vcnt_reg;
            o_track_reg <= track;
            o_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_ch_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = dwcp_pkg::M_TDATA_W'({o_track_reg, o_vcnt_reg, o_mean_reg,
                                            o_gp_reg, o_gy_reg, o_gx_reg,
                                            o_y_reg, o_x_reg});

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten before the beat was taken");

    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && last_reg) |=> (gcnt_reg == '0))
        else $error("good chamber count not cleared at end of event");

    a_div_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !div_done)
        else $error("divider did not start on a new chamber");

endmodule

/* rtl/dwcp_ctrl.sv */
// dwcp_ctrl: sequencer that steps one chamber through the shared multiplier
// passes and hands the result to the output register. Uses dwcp_pkg.
module dwcp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  dwcp_pkg::dp_status_t  status,
    output dwcp_pkg::dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MX,
        ST_MY,
        ST_MRY,
        ST_MRX,
        ST_FIN
    } state_t;

    state_t            state_reg;
    logic              ready_reg;
    dwcp_pkg::mul_op_t op_reg;
    logic              load;
    logic              out_load;

    assign load     = s_tvalid && ready_reg;
    assign out_load = (state_reg == ST_FIN) && status.div_done && status.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            op_reg    <= dwcp_pkg::OP_NONE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (load) begin
                        state_reg <= ST_MX;
                        ready_reg <= 1'b0;
                        op_reg    <= dwcp_pkg::OP_MX;
                    end
                end
                ST_MX: begin
                    state_reg <= ST_MY;
                    op_reg    <= dwcp_pkg::OP_MY;
                end
                ST_MY: begin
                    state_reg <= ST_MRY;
                    op_reg    <= dwcp_pkg::OP_MRY;
                end
                ST_MRY: begin
                    state_reg <= ST_MRX;
                    op_reg    <= dwcp_pkg::OP_MRX;
                end
                ST_MRX: begin
                    state_reg <= ST_FIN;
                    op_reg    <= dwcp_pkg::OP_NONE;
                end
                ST_FIN: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                    op_reg    <= dwcp_pkg::OP_NONE;
                end
            endcase
        end
    end

    assign s_tready     = ready_reg;
    assign cmd.load     = load;
    assign cmd.op       = op_reg;
    assign cmd.out_load = out_load;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (state_reg == ST_MX && op_reg == dwcp_pkg::OP_MX))
        else $error("accepted chamber did not start the x pass");

    a_fin_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !out_load) |=> (state_reg == ST_FIN && !ready_reg))
        else $error("finished chamber left before its result was stored");

endmodule

/* verif/delay_wire_chamber_position_core_tb.sv */
// delay_wire_chamber_position_core_tb: stream-level test of the chamber position core.
// Walks a directed stimulus table and then random events over several calibration sets,
// predicting each result beat in the bench unless its row gives one. Depends on dwcp_pkg and the core RTL.
module delay_wire_chamber_position_core_tb;

    localparam int TW = dwcp_pkg::TIME_BITS;

    localparam logic [dwcp_pkg::CFG_IDX_W-1:0] REG_CAL0   = 3'd0;
    localparam logic [dwcp_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [dwcp_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    localparam longint T_MAX  = 2097151;
    localparam longint T_MIN  = -2097152;
    localparam longint T_NONE = -1;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 250;
    localparam int N_PHASES      = 7;

    typedef struct packed {
        logic [1:0]    ch;
        logic [TW-1:0] tl;
        logic [TW-1:0] tr;
        logic [TW-1:0] td;
        logic [TW-1:0] tu;
        logic          last;
    } chamber_hits_t;

    typedef struct packed {
        logic [1:0]  ch;
        logic [15:0] x;
        logic [15:0] y;
        logic        gx;
        logic        gy;
        logic        gp;
        logic [20:0] mean;
        logic [2:0]  cnt;
        logic        track;
        logic        last;
    } chamber_point_t;

    typedef struct packed {
        chamber_hits_t  hits;
        logic           typed;
        chamber_point_t pt;
    } stim_row_t;

    localparam chamber_point_t NO_HIT_POINT = '{ch: 2'd0, x: 16'd0, y: 16'd0, gx: 1'b0,
        gy: 1'b0, gp: 1'b0, mean: 21'd0, cnt: 3'd0, track: 1'b0, last: 1'b0};
    localparam chamber_point_t ZERO_TIME_POINT = '{ch: 2'd1, x: 16'd0, y: 16'd0, gx: 1'b1,
        gy: 1'b1, gp: 1'b1, mean: 21'd0, cnt: 3'd4, track: 1'b0, last: 1'b0};
    localparam chamber_point_t FULL_SCALE_POINT = '{ch: 2'd2, x: 16'd0, y: 16'd0, gx: 1'b1,
        gy: 1'b1, gp: 1'b1, mean: 21'h1FFFFF, cnt: 3'd4, track: 1'b0, last: 1'b1};
    localparam chamber_point_t NO_HIT_LAST_POINT = '{ch: 2'd3, x: 16'd0, y: 16'd0, gx: 1'b0,
        gy: 1'b0, gp: 1'b0, mean: 21'd0, cnt: 3'd0, track: 1'b0, last: 1'b1};

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [dwcp_pkg::S_TDATA_W-1:0]     s_tdata;   // t_left, t_right, t_down, t_up
    logic [dwcp_pkg::CH_W-1:0]          s_tuser;   // chamber
    logic                               s_tlast;   // last_chamber
    logic                               m_tvalid;
    logic                               m_tready;
    // x_position, y_position, good_x, good_y, good_point, mean_time, valid_count,
    // track_ok, zero pad
    logic [dwcp_pkg::M_TDATA_W-1:0]     m_tdata;
    logic [dwcp_pkg::CH_W-1:0]          m_tuser;   // chamber_out
    logic                               m_tlast;   // last_out
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [dwcp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [dwcp_pkg::CAL_W-1:0]         cfg_data;

    // bench copy of the block's registers and event state
    logic [63:0]    cal_word [4];
    logic [13:0]    window_mm;
    logic [2:0]     track_min;
    logic [2:0]     good_chambers;

    chamber_point_t awaited_points [$];
    stim_row_t      directed_rows [$];
    logic           use_typed;
    chamber_point_t typed_point;
    logic           in_taken;
    logic           cfg_taken;
    logic           steady;
    logic           hold_off;
    int             mismatches = 0;
    int             cycle_count = 0;

    delay_wire_chamber_position_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [15:0] clamp_pos(input longint v);
        if (v > 32767) begin
            return 16'h7FFF;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic chamber_point_t reconstruct_chamber(input chamber_hits_t h);
        chamber_point_t r;
        logic [63:0] cal;
        longint tl, tr, td, tu, slx, sly, ofx, ofy, rot, sum;
        longint rawx, rawy, ax, ay, rx, ry;
        int nvalid;
        logic vl, vr, vd, vu, vx, vy;
        cal = cal_word[h.ch];
        slx = cal[63:52];
        sly = cal[51:40];
        ofx = $signed(cal[39:26]);
        ofy = $signed(cal[25:12]);
        rot = $signed(cal[11:0]);
        tl = $signed(h.tl);
        tr = $signed(h.tr);
        td = $signed(h.td);
        tu = $signed(h.tu);
        vl = tl >= 0;
        vr = tr >= 0;
        vd = td >= 0;
        vu = tu >= 0;
        sum = (vl ? tl : 0) + (vr ? tr : 0) + (vd ? td : 0) + (vu ? tu : 0);
        nvalid = int'(vl) + int'(vr) + int'(vd) + int'(vu);
        vx = vl && vr;
        vy = vd && vu;
        rawx = vx ? ((tl - tr) * slx) >>> 8 : 0;
        rawy = vy ? ((td - tu) * sly) >>> 8 : 0;
        r.gx = vx && ((rawx < 0 ? -rawx : rawx) <= longint'(window_mm));
        r.gy = vy && ((rawy < 0 ? -rawy : rawy) <= longint'(window_mm));
        // x uses raw y for rotation, y uses aligned x when good, raw x otherwise
        ry = vy ? rawy : 0;
        ax = rawx - ofx - ((ry * rot) >>> 14);
        rx = r.gx ? ax : (vx ? rawx : 0);
        ay = rawy - ofy + ((rx * rot) >>> 14);
        r.gp = r.gx && r.gy;
        if (r.gp && good_chambers != 3'd7) begin
            good_chambers = good_chambers + 3'd1;
        end
        r.track = h.last && (good_chambers >= track_min);
        if (h.last) begin
            good_chambers = 3'd0;
        end
        r.ch = h.ch;
        r.x = r.gx ? clamp_pos(ax) : 16'd0;
        r.y = r.gy ? clamp_pos(ay) : 16'd0;
        r.mean = (nvalid != 0) ? 21'(sum / nvalid) : 21'd0;
        r.cnt = 3'(nvalid);
        r.last = h.last;
        return r;
    endfunction

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, e, a);
        end
    endtask

    task automatic compare_point(input chamber_point_t e, input chamber_point_t g);
        check_field("chamber_out", e.ch, g.ch);
        check_field("x_position", $signed(e.x), $signed(g.x));
        check_field("y_position", $signed(e.y), $signed(g.y));
        check_field("good_x", e.gx, g.gx);
        check_field("good_y", e.gy, g.gy);
        check_field("good_point", e.gp, g.gp);
        check_field("mean_time", e.mean, g.mean);
        check_field("valid_count", e.cnt, g.cnt);
        check_field("track_ok", e.track, g.track);
        check_field("last_out", e.last, g.last);
    endtask

    // handshakes seen at the rising edge
    always @(posedge aclk) begin
        chamber_hits_t  h;
        chamber_point_t got;
        chamber_point_t pred;
        if (!aresetn) begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
        end else begin
            in_taken  <= s_tvalid && s_tready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dwcp_pkg::REG_WINDOW: window_mm = cfg_data[13:0];
                    dwcp_pkg::REG_THRESH: track_min = cfg_data[2:0];
                    default: begin
                        if (cfg_index <= dwcp_pkg::REG_CAL3) begin
                            cal_word[cfg_index[1:0]] = cfg_data;
                        end
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.ch    = m_tuser;
                got.x     = m_tdata[15:0];
                got.y     = m_tdata[31:16];
                got.gx    = m_tdata[32];
                got.gy    = m_tdata[33];
                got.gp    = m_tdata[34];
                got.mean  = m_tdata[55:35];
                got.cnt   = m_tdata[58:56];
                got.track = m_tdata[59];
                got.last  = m_tlast;
                if (awaited_points.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat for chamber %0d with nothing expected",
                             $time, got.ch);
                end else begin
                    compare_point(awaited_points.pop_front(), got);
                end
            end
            if (s_tvalid && s_tready) begin
                h.ch   = s_tuser;
                h.tl   = s_tdata[TW-1:0];
                h.tr   = s_tdata[2*TW-1:TW];
                h.td   = s_tdata[3*TW-1:2*TW];
                h.tu   = s_tdata[4*TW-1:3*TW];
                h.last = s_tlast;
                pred = reconstruct_chamber(h);
                awaited_points.push_back(use_typed ? typed_point : pred);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    initial begin : receiver
        int wait_left;
        m_tready = 1'b0;
        wait_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                hold_off = 1'b0;
                wait_left = HOLD_CYCLES;
            end
            if (wait_left > 0) begin
                m_tready = 1'b0;
                wait_left--;
            end else if (steady || $urandom_range(0, 99) < 75) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                wait_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
            end
        end
    end

    function automatic int sender_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 65) begin
            return 0;
        end
        if (p < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TW-1:0] draw_time(input longint base);
        int p;
        longint t;
        p = $urandom_range(0, 99);
        if (p < 8) begin
            t = -longint'($urandom_range(1, 2097152));
        end else if (p < 12) begin
            case ($urandom_range(0, 2))
                0: t = T_MAX;
                1: t = 0;
                default: t = T_MIN;
            endcase
        end else if (p < 25) begin
            t = $urandom;
        end else begin
            t = base + longint'($urandom_range(0, 20000)) - 10000;
            if (t < 0) begin
                t = 0;
            end
        end
        return t[TW-1:0];
    endfunction

    function automatic stim_row_t mk_row(input logic [1:0] ch, input longint l, input longint r,
                                         input longint d, input longint u, input logic last,
                                         input logic typed, input chamber_point_t pt);
        stim_row_t row;
        row.hits.ch   = ch;
        row.hits.tl   = TW'(l);
        row.hits.tr   = TW'(r);
        row.hits.td   = TW'(d);
        row.hits.tu   = TW'(u);
        row.hits.last = last;
        row.typed     = typed;
        row.pt        = pt;
        return row;
    endfunction

    task automatic offer_chamber(input chamber_hits_t h, input logic typed,
                                 input chamber_point_t pt, input int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata   = {h.tu, h.td, h.tr, h.tl};
        s_tuser   = h.ch;
        s_tlast   = h.last;
        use_typed = typed;
        typed_point = pt;
        s_tvalid  = 1'b1;
        do @(negedge aclk); while (!in_taken);
    endtask

    task automatic write_reg(input logic [dwcp_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(negedge aclk); while (!cfg_taken);
    endtask

    task automatic load_settings(input logic [3:0][63:0] cals, input logic [13:0] win,
                                 input logic [2:0] thr);
        logic [63:0] word;
        for (int i = 0; i < 4; i++) begin
            write_reg(REG_CAL0 + 3'(i), cals[i]);
        end
        word = {$urandom, $urandom};
        word[13:0] = win;
        write_reg(dwcp_pkg::REG_WINDOW, word);
        word = {$urandom, $urandom};
        word[2:0] = thr;
        write_reg(dwcp_pkg::REG_THRESH, word);
        cfg_valid = 1'b0;
    endtask

    // wait until every result beat has come back
    task automatic settle();
        s_tvalid = 1'b0;
        while (awaited_points.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_events(input int n, input int burst);
        chamber_hits_t h;
        logic [1:0] ch;
        longint base;
        int len, p, sent;
        sent = 0;
        while (sent < n) begin
            p = $urandom_range(0, 99);
            len = (p < 70) ? $urandom_range(1, 4) : (p < 95) ? $urandom_range(5, 7)
                                                             : $urandom_range(8, 10);
            if (len > n - sent) begin
                len = n - sent;
            end
            ch = 2'($urandom);
            base = $urandom_range(10000, 2087151);
            for (int k = 0; k < len; k++) begin
                h.ch   = ch;
                h.tl   = draw_time(base);
                h.tr   = draw_time(base);
                h.td   = draw_time(base);
                h.tu   = draw_time(base);
                h.last = (k == len - 1);
                offer_chamber(h, 1'b0, NO_HIT_POINT, (sent < burst) ? 0 : sender_gap());
                sent++;
                ch = ($urandom_range(0, 4) == 0) ? 2'($urandom) : ch + 2'd1;
            end
        end
    endtask

    initial begin : stimulus
        logic [3:0][63:0] cals;
        int sx, sy, ox, oy, rt;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        use_typed = 1'b0;
        typed_point = NO_HIT_POINT;
        steady    = 1'b0;
        hold_off  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            cal_word[i] = dwcp_pkg::CAL_RESET;
        end
        window_mm     = dwcp_pkg::WINDOW_RESET;
        track_min     = dwcp_pkg::THRESH_RESET;
        good_chambers = 3'd0;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset calibration: slope 328, no offset, no rotation, window 50 mm, threshold 3
        directed_rows.push_back(mk_row(2'd0, T_NONE, T_NONE, T_NONE, T_NONE, 1'b0,
                                       1'b1, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd1, 0, 0, 0, 0, 1'b0, 1'b1, ZERO_TIME_POINT));
        directed_rows.push_back(mk_row(2'd2, T_MAX, T_MAX, T_MAX, T_MAX, 1'b1,
                                       1'b1, FULL_SCALE_POINT));
        directed_rows.push_back(mk_row(2'd3, T_MIN, T_MIN, T_MIN, T_MIN, 1'b1,
                                       1'b1, NO_HIT_LAST_POINT));
        directed_rows.push_back(mk_row(2'd0, T_MAX, 0, 0, T_MAX, 1'b0, 1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd1, 0, T_MAX, T_MAX, 0, 1'b0, 1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd2, 100000, 99000, 5000, 6000, 1'b0,
                                       1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd3, -5, 7, 8, 9, 1'b0, 1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd0, 3, -1, 10, 11, 1'b0, 1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd1, 5, 6, -7, 8, 1'b0, 1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd2, 5, 6, 7, -8, 1'b1, 1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd3, 1, 2, 2, 2, 1'b1, 1'b0, NO_HIT_POINT));
        // window edges, then good-count overflow ahead of the last mark
        directed_rows.push_back(mk_row(2'd0, 9991, 0, 0, 9990, 1'b0, 1'b0, NO_HIT_POINT));
        directed_rows.push_back(mk_row(2'd1, 9992, 0, 0, 9991, 1'b0, 1'b0, NO_HIT_POINT));
        for (int i = 0; i < 8; i++) begin
            directed_rows.push_back(mk_row(2'(i), 0, 0, 0, 0, 1'b0, 1'b0, NO_HIT_POINT));
        end
        directed_rows.push_back(mk_row(2'd3, 0, 0, 0, 0, 1'b1, 1'b0, NO_HIT_POINT));

        foreach (directed_rows[i]) begin
            offer_chamber(directed_rows[i].hits, directed_rows[i].typed, directed_rows[i].pt,
                          sender_gap());
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(REG_SPARE6, {$urandom, $urandom});
                    write_reg(REG_SPARE7, {$urandom, $urandom});
                    cfg_valid = 1'b0;
                end
                1: load_settings({4{64'hFFFF_FFFF_FFFF_FFFF}}, 14'h3FFF, 3'd4);
                2: load_settings('0, 14'd0, 3'd0);
                3: begin
                    for (int i = 0; i < 4; i++) begin
                        sx = $urandom_range(250, 400);
                        sy = $urandom_range(250, 400);
                        ox = int'($urandom_range(0, 2000)) - 1000;
                        oy = int'($urandom_range(0, 2000)) - 1000;
                        rt = int'($urandom_range(0, 400)) - 200;
                        cals[i] = {12'(sx), 12'(sy), 14'(ox), 14'(oy), 12'(rt)};
                    end
                    load_settings(cals, 14'($urandom_range(8000, 16383)),
                                  3'($urandom_range(0, 4)));
                end
                default: begin
                    for (int i = 0; i < 4; i++) begin
                        cals[i] = {$urandom, $urandom};
                    end
                    load_settings(cals, 14'($urandom), 3'($urandom_range(0, 4)));
                end
            endcase
            steady = (phase == 4);
            if (phase == 3) begin
                hold_off = 1'b1;
            end
            run_events(PHASE_ITEMS, (phase == 3) ? 40 : 0);
        end
        settle();

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* delay_wire_chamber_position_core.f */
rtl/dwcp_pkg.sv
rtl/dwcp_div.sv
rtl/dwcp_datapath.sv
rtl/dwcp_ctrl.sv
rtl/delay_wire_chamber_position_core.sv
verif/delay_wire_chamber_position_core_tb.sv
